// ===== sv/swmax_pkg.sv =====
// ----------------------------------------------------------------------------
// swmax_pkg
// Shared types and fixed widths of the sliding window maximum core.
// ----------------------------------------------------------------------------
`default_nettype none

package swmax_pkg;

  // Stream positions wrap modulo 2**POS_BITS.
  localparam int POS_BITS = 16;

  // Width of the window size register.
  localparam int CFG_BITS = 7;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

endpackage : swmax_pkg

`default_nettype wire

// ===== sv/swmax_deque_mem.sv =====
// ----------------------------------------------------------------------------
// swmax_deque_mem
// Candidate store: value and stream position per entry, one write port and
// two registered read ports, with write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module swmax_deque_mem
  import swmax_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  wire logic [VALUE_BITS-1:0]          wr_value,
  input  wire logic [POS_BITS-1:0]            wr_pos,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_a_addr,
  output logic      [VALUE_BITS-1:0]          rd_a_value,
  output logic      [POS_BITS-1:0]            rd_a_pos,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_b_addr,
  output logic      [VALUE_BITS-1:0]          rd_b_value,
  output logic      [POS_BITS-1:0]            rd_b_pos
);

  localparam int ENTRY_BITS = VALUE_BITS + POS_BITS;

  logic [ENTRY_BITS-1:0] mem [DEPTH];
  logic [ENTRY_BITS-1:0] rd_a_r;
  logic [ENTRY_BITS-1:0] rd_b_r;
  logic [ENTRY_BITS-1:0] wr_entry;

  assign wr_entry = {wr_value, wr_pos};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Forward the entry being written so a read of the same slot sees it.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_a_addr)) begin
      rd_a_r <= wr_entry;
    end else begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (wr_en && (wr_addr == rd_b_addr)) begin
      rd_b_r <= wr_entry;
    end else begin
      rd_b_r <= mem[rd_b_addr];
    end
  end

  assign rd_a_value = rd_a_r[ENTRY_BITS-1:POS_BITS];
  assign rd_a_pos   = rd_a_r[POS_BITS-1:0];
  assign rd_b_value = rd_b_r[ENTRY_BITS-1:POS_BITS];
  assign rd_b_pos   = rd_b_r[POS_BITS-1:0];

endmodule : swmax_deque_mem

`default_nettype wire

// ===== sv/sliding_window_maximum_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// Streaming sliding window maximum over a monotonic deque held in memory.
// ----------------------------------------------------------------------------
// Flow: IDLE registers an accepted beat; EVAL then drops stale front and
//   dominated back candidates one at a time, front first, and appends the
//   sample, loading the output register; the append waits while a result is
//   still held. Each sample is dropped at most once. in_stall is high outside
//   IDLE, and reads of the candidate memory are registered.
// Reset: synchronous, active low; clears the sequencer, deque pointers,
//   stream position, output valid, and sets window size to 1. The candidate
//   memory is not cleared: the fill count keeps unwritten entries unread.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum_core
  import swmax_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [CFG_BITS-1:0]           cfg_window_size,
  // sample channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_end_of_stream,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_window_max,
  output logic                               out_final_res
);

  localparam int IDX_BITS = $clog2(MAX_WINDOW);
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS = CNT_BITS + 1;

  // Ring slot arithmetic: base + offset modulo MAX_WINDOW, the sum always
  // stays below twice the depth, so one compare and subtract wraps it.
  function automatic logic [IDX_BITS-1:0] slot_add(input logic [IDX_BITS-1:0] base,
                                                   input logic [CNT_BITS-1:0] off);
    logic [SUM_BITS-1:0] sum;
    sum = SUM_BITS'(base) + SUM_BITS'(off);
    if (sum >= SUM_BITS'(MAX_WINDOW)) begin
      sum = sum - SUM_BITS'(MAX_WINDOW);
    end
    return sum[IDX_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [CFG_BITS-1:0]     window_size_r;
  logic [IDX_BITS-1:0]     head_r, head_nxt;
  logic [CNT_BITS-1:0]     count_r, count_nxt;
  logic [POS_BITS-1:0]     stream_pos_r, stream_pos_nxt;
  logic                    filled_r, filled_nxt;

  // Captured input beat.
  logic [SAMPLE_BITS-1:0]  sample_r;
  logic                    eos_r;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]  out_max_r, out_max_nxt;
  logic                    out_final_r, out_final_nxt;

  // Memory ports.
  logic                    wr_en;
  logic [IDX_BITS-1:0]     wr_addr;
  logic [IDX_BITS-1:0]     rd_head_addr;
  logic [IDX_BITS-1:0]     rd_tail_addr;
  logic [SAMPLE_BITS-1:0]  head_value;
  logic [POS_BITS-1:0]     head_pos;
  logic [SAMPLE_BITS-1:0]  tail_value;
  logic [POS_BITS-1:0]     tail_pos;

  // Evaluation terms.
  logic [CFG_BITS-1:0]     win_k;
  logic [POS_BITS-1:0]     head_age;
  logic                    head_expired;
  logic                    tail_dominated;
  logic                    out_free;
  logic                    in_accept;
  logic                    emit;

  swmax_deque_mem #(
    .DEPTH      (MAX_WINDOW),
    .VALUE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_value   (sample_r),
    .wr_pos     (stream_pos_r),
    .rd_a_addr  (rd_head_addr),
    .rd_a_value (head_value),
    .rd_a_pos   (head_pos),
    .rd_b_addr  (rd_tail_addr),
    .rd_b_value (tail_value),
    .rd_b_pos   (tail_pos)
  );

  // Effective window: zero counts as one, saturate at the deque depth.
  always_comb begin
    if (window_size_r == '0) begin
      win_k = CFG_BITS'(1);
    end else if (32'(window_size_r) > 32'(MAX_WINDOW)) begin
      win_k = CFG_BITS'(MAX_WINDOW);
    end else begin
      win_k = window_size_r;
    end
  end

  // Head leaves the window once its age reaches the window size. Tail
  // position is unused: only its value decides a back drop.
  assign head_age       = stream_pos_r - head_pos;
  assign head_expired   = (count_r != '0) && (head_age >= POS_BITS'(win_k));
  assign tail_dominated = (count_r != '0) &&
                          ($signed(tail_value) <= $signed(sample_r));

  // Emit once the window has filled for this stream.
  assign emit = filled_r ||
                ((POS_BITS+1)'(stream_pos_r) + (POS_BITS+1)'(1) >=
                 (POS_BITS+1)'(win_k));

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Sequencer: one drop per EVAL cycle, front before back, then append
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    stream_pos_nxt = stream_pos_r;
    filled_nxt     = filled_r;
    out_max_nxt    = out_max_r;
    out_final_nxt  = out_final_r;
    wr_en          = 1'b0;
    wr_addr        = slot_add(head_r, count_r);

    // Drain the output register when the beat is taken.
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (head_expired) begin
          // Drop the stale head and advance.
          head_nxt  = slot_add(head_r, CNT_BITS'(1));
          count_nxt = count_r - CNT_BITS'(1);
        end else if (tail_dominated) begin
          // Drop a back candidate not greater than the new sample.
          count_nxt = count_r - CNT_BITS'(1);
        end else if (out_free) begin
          // Append the sample; hold here while a result still waits.
          wr_en = 1'b1;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_max_nxt   = (count_r == '0) ? sample_r : head_value;
            out_final_nxt = eos_r;
          end
          if (eos_r) begin
            head_nxt       = '0;
            count_nxt      = '0;
            stream_pos_nxt = '0;
            filled_nxt     = 1'b0;
          end else begin
            count_nxt      = count_r + CNT_BITS'(1);
            stream_pos_nxt = stream_pos_r + POS_BITS'(1);
            if (stream_pos_r == '1) begin
              filled_nxt = 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Read ahead from the next pointers so the registered read data matches the
  // registers; the memory forwards the append slot.
  assign rd_head_addr = head_nxt;
  assign rd_tail_addr = (count_nxt == '0) ? head_nxt
                                          : slot_add(head_nxt, count_nxt - CNT_BITS'(1));

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_size_r <= CFG_BITS'(1);
      head_r        <= '0;
      count_r       <= '0;
      stream_pos_r  <= '0;
      filled_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      stream_pos_r  <= stream_pos_nxt;
      filled_r      <= filled_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        window_size_r <= cfg_window_size;
      end
    end
  end

  // Payload: capture the beat and the result, no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_sample;
      eos_r    <= in_end_of_stream;
    end
    out_max_r   <= out_max_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;
  assign out_final_res  = out_final_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The deque never holds more candidates than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(MAX_WINDOW))
    else $error("deque count exceeded its depth");

  // A result is only loaded by an append step.
  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EVAL))
    else $error("result appeared outside an append step");

  // An accepted beat goes to evaluation with its position untouched.
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_EVAL) && $stable(stream_pos_r))
    else $error("accepted beat did not enter evaluation");

  // A front drop removes exactly one candidate.
  a_front_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && head_expired |=> count_r == $past(count_r) - CNT_BITS'(1))
    else $error("front drop miscounted");

endmodule : sliding_window_maximum_core

`default_nettype wire

// ===== dv/tb_sliding_window_maximum_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_maximum_core
// Self-checking bench for the sliding window maximum core. A local monotonic
// deque predicts each window maximum from the accepted sample beats. Results
// are checked in order against that prediction under random idling, a long
// result hold-off, window size changes and a stream that fills the deque to
// its depth.
// ----------------------------------------------------------------------------

module tb_sliding_window_maximum_core
  import swmax_pkg::*;
();

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_BITS  = 32;
  localparam int DRAIN_CYCLES = 100;      // worst drop run plus pipeline, with margin
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_BEATS  = 200;
  localparam int LONG_BEATS   = 120;
  localparam int FALL_BEATS   = 70;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          eos;
  } sample_beat_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] wmax;
    logic                          fin;
  } win_result_t;

  // --------------------------------------------------------------------------
  // DUT connections
  // --------------------------------------------------------------------------
  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [CFG_BITS-1:0]           cfg_window_size;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_end_of_stream;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_window_max;
  logic                          out_final_res;

  sliding_window_maximum_core #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_window_size  (cfg_window_size),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window_max   (out_window_max),
    .out_final_res    (out_final_res)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  sample_beat_t pending_beats[$];     // beats not yet put on the input port
  win_result_t  expected_max_q[$];    // predicted window maxima, oldest first
  sample_beat_t next_beat;
  win_result_t  want;

  int  n_queued;                      // beats pushed into pending_beats
  int  n_accepted;                    // beats taken by the core
  int  n_err;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_left;                     // cycles left in a forced result hold-off
  bit  in_taken;                      // input beat accepted at the last rising edge

  // Local deque: values, positions and pointers, plus the window register copy.
  logic signed [SAMPLE_BITS-1:0] dq_value [MAX_WINDOW];
  logic [POS_BITS-1:0]           dq_pos   [MAX_WINDOW];
  logic [5:0]                    dq_head;
  logic [6:0]                    dq_count;
  logic [POS_BITS-1:0]           next_pos;
  bit                            pos_wrapped;
  logic [CFG_BITS-1:0]           win_cfg;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: advance the local deque by one sample and queue the maximum
  // when the window is full (or the position counter has wrapped).
  // --------------------------------------------------------------------------
  task automatic window_max_step(input logic signed [SAMPLE_BITS-1:0] smp,
                                 input logic eos);
    int                 k;
    logic [POS_BITS-1:0] age;
    logic [5:0]         tail;
    win_result_t        res;
    // zero means one; anything past the deque depth saturates
    k = (win_cfg == 0) ? 1 : ((int'(win_cfg) > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg));
    // drop candidates that have left the window (age taken modulo 2**16)
    while (dq_count != 0) begin
      age = next_pos - dq_pos[dq_head];
      if (age < k) break;
      dq_head++;
      dq_count--;
    end
    // drop trailing candidates that are not greater than the new sample
    while (dq_count != 0) begin
      tail = dq_head + dq_count[5:0] - 6'd1;
      if (dq_value[tail] > smp) break;
      dq_count--;
    end
    // full deque: drop the oldest to make room
    if (dq_count >= 7'(MAX_WINDOW)) begin
      dq_head++;
      dq_count--;
    end
    tail = dq_head + dq_count[5:0];
    dq_value[tail] = smp;
    dq_pos[tail]   = next_pos;
    dq_count++;
    if (pos_wrapped || (int'(next_pos) + 1 >= k)) begin
      res.wmax = dq_value[dq_head];
      res.fin  = eos;
      expected_max_q.push_back(res);
    end
    if (eos) begin
      dq_head     = '0;
      dq_count    = '0;
      next_pos    = '0;
      pos_wrapped = 1'b0;
    end else begin
      next_pos++;
      if (next_pos == 0) pos_wrapped = 1'b1;
    end
  endtask

  task automatic note_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("%0t: ERROR %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic eos);
    sample_beat_t b;
    b.smp = smp;
    b.eos = eos;
    pending_beats.push_back(b);
    n_queued++;
  endtask

  // Mix extremes, a narrow band around zero (ties and equal drops) and the full range.
  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed(32'($urandom_range(8))) - 32'sd4;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // Hold until every queued beat is taken and every result has come, then let
  // a beat that yields no result finish its drops before anything else moves.
  task automatic wait_drained();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_max_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the window size; only called while the core is drained.
  task automatic write_window_size(input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_wr_en       = 1'b1;
    cfg_window_size = val;
    @(negedge clk);
    cfg_wr_en       = 1'b0;
    win_cfg         = val;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: on the falling edge, offer the next pending beat unless the
  // current one is still waiting or the sender idles this cycle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat        = pending_beats.pop_front();
        in_valid         <= 1'b1;
        in_sample        <= next_beat.smp;
        in_end_of_stream <= next_beat.eos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: a forced hold-off first, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, check a taken result against the oldest
  // prediction, then advance the predictor with a taken sample beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_max_q.size() == 0) begin
        note_error($sformatf("unexpected result max=%0d final=%0b",
                             out_window_max, out_final_res));
      end else begin
        want = expected_max_q.pop_front();
        if (out_window_max !== want.wmax)
          note_error($sformatf("window_max expected %0d got %0d", want.wmax, out_window_max));
        if (out_final_res !== want.fin)
          note_error($sformatf("final_res expected %0b got %0b", want.fin, out_final_res));
      end
    end
    if (in_taken) begin
      n_accepted++;
      window_max_step(in_sample, in_end_of_stream);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_window_maximum_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int                   k;
    int                   len;
    int                   phase_beats;
    logic [CFG_BITS-1:0]  wsel;
    logic signed [SAMPLE_BITS-1:0] base;

    // drive every input to a known value and clear the predictor
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_window_size  = '0;
    in_valid         = 1'b0;
    in_sample        = '0;
    in_end_of_stream = 1'b0;
    out_stall        = 1'b0;
    in_taken         = 1'b0;
    hold_left        = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    n_queued         = 0;
    n_accepted       = 0;
    n_err            = 0;
    cycle_count      = 0;
    dq_head          = '0;
    dq_count         = '0;
    next_pos         = '0;
    pos_wrapped      = 1'b0;
    win_cfg          = 7'd1;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      dq_value[i] = '0;
      dq_pos[i]   = '0;
    end

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: window of one after reset, sample extremes.
    queue_sample(32'sh7fff_ffff, 1'b0);
    queue_sample(32'sh8000_0000, 1'b0);
    queue_sample(-32'sd1, 1'b1);
    wait_drained();

    // Directed: window size zero behaves as one; equal samples.
    write_window_size(7'd0);
    queue_sample(32'sd5, 1'b0);
    queue_sample(32'sd5, 1'b0);
    queue_sample(-32'sd2, 1'b1);
    wait_drained();

    // Directed: window of three; front eviction, back drops, ties.
    write_window_size(7'd3);
    queue_sample(32'sd1, 1'b0);
    queue_sample(32'sd3, 1'b0);
    queue_sample(-32'sd1, 1'b0);
    queue_sample(-32'sd3, 1'b0);
    queue_sample(32'sd5, 1'b0);
    queue_sample(32'sd4, 1'b0);
    queue_sample(32'sd4, 1'b1);
    wait_drained();

    // Directed: all-ones register saturates to the deque depth; a stream
    // shorter than the window yields nothing.
    write_window_size(7'd127);
    queue_sample(32'sd9, 1'b0);
    queue_sample(32'sh8000_0000, 1'b0);
    queue_sample(32'sh7fff_ffff, 1'b0);
    queue_sample(32'sd0, 1'b1);
    wait_drained();

    // Directed: change the window in the middle of a stream.
    write_window_size(7'd2);
    queue_sample(32'sd9, 1'b0);
    queue_sample(32'sd1, 1'b0);
    queue_sample(32'sd7, 1'b0);
    wait_drained();
    write_window_size(7'd5);
    queue_sample(32'sd2, 1'b0);
    queue_sample(32'sd3, 1'b0);
    queue_sample(-32'sd6, 1'b1);
    wait_drained();

    // Long stream at the largest window. Open with a strictly falling run so
    // the deque fills to its depth, then go random.
    write_window_size(7'd64);
    base = $signed(32'($urandom_range(1000, 100000)));
    for (int i = 0; i < LONG_BEATS; i++) begin
      if (i < FALL_BEATS) queue_sample(base - i, 1'b0);
      else                queue_sample(draw_sample(), i == LONG_BEATS - 1);
    end
    wait_drained();

    // Random phases: streams of random length under four idling settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin wsel = 7'($urandom_range(2, 16)); send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin wsel = 7'd1;                      send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin wsel = 7'd64;                     send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin
          wsel = 7'($urandom_range(0, 127)); send_idle_pct = 35; recv_stall_pct = 35;
        end
      endcase
      write_window_size(wsel);
      k = (wsel == 0) ? 1 : ((int'(wsel) > MAX_WINDOW) ? MAX_WINDOW : int'(wsel));
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        // mostly streams that fill the window, some shorter than it
        if ($urandom_range(9) == 0) len = (k > 1) ? $urandom_range(1, k - 1) : 1;
        else                        len = $urandom_range(1, 3 * k + 4);
        for (int i = 0; i < len; i++) queue_sample(draw_sample(), i == len - 1);
        phase_beats += len;
      end
      // Hold off the result side while the sender keeps offering beats, so
      // the core backs up and stalls its input.
      if (ph == 0) begin
        @(posedge clk);
        hold_left = 600;
      end
      wait_drained();
    end

    if (n_err == 0 && expected_max_q.size() == 0) begin
      $display("sliding_window_maximum_core verification clean");
    end else begin
      $display("sliding_window_maximum_core verification failed");
    end
    $finish;
  end

endmodule
